[rtl/core/scbp_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants of the size-class buffer pool.
// No dependencies; used by scbp_ctrl, scbp_dpath and size_class_buffer_pool.
package scbp_pkg;

    localparam int POOL_ENTRIES_DEF  = 32;
    localparam int MIN_CLASS_EXP_DEF = 8;
    localparam int MAX_RESULTS       = 32;
    localparam int RES_CNT_W         = 6;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 64;
    localparam int TOTAL_W    = 38;

    // command codes
    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;
    localparam logic [1:0] CMD_TRIM    = 2'd2;

    // result status codes
    localparam logic [2:0] ST_REUSED    = 3'd0;
    localparam logic [2:0] ST_CREATED   = 3'd1;
    localparam logic [2:0] ST_FULL      = 3'd2;
    localparam logic [2:0] ST_RELEASED  = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;
    localparam logic [2:0] ST_REMOVED   = 3'd5;
    localparam logic [2:0] ST_NOTHING   = 3'd6;

    // configuration register indexes
    localparam logic CFG_BUDGET = 1'b0;
    localparam logic CFG_DELAY  = 1'b1;

    localparam logic [TOTAL_W-1:0] BUDGET_RESET = 38'd134217728;
    localparam logic [7:0]         DELAY_RESET  = 8'd3;

    // one pool entry as held in the entry memory
    typedef struct packed {
        logic [15:0] ident;
        logic [31:0] free_after;
        logic        busy;
        logic [5:0]  cls;
    } entry_t;

    // one result word, last field in the lowest bits
    typedef struct packed {
        logic [TOTAL_W-1:0] total;
        logic [5:0]         cls;
        logic [15:0]        id;
        logic [2:0]         status;
    } res_t;

    // commands from controller to datapath
    typedef struct packed {
        logic latch;
        logic rd;
        logic ev;
        logic fin;
    } ctl_t;

    // status from datapath to controller
    typedef struct packed {
        logic [1:0] acc_cmd;
        logic       over_budget;
        logic       scan_done;
        logic       ev_stall;
        logic       out_free;
        logic       held_vld;
        logic       count_zero;
        logic       total_zero;
    } sts_t;

    // round a byte count up to a power-of-two class with a floor
    function automatic logic [5:0] class_of(input logic [31:0] req,
                                            input logic [5:0] min_exp);
        logic [31:0] m;
        logic [5:0]  e;
        m = req - 32'd1;
        e = 6'd0;
        for (int b = 0; b < 32; b++)
        begin
            if (m[b])
            begin
                e = 6'(b + 1);
            end
        end
        if (req == 32'd0 || e < min_exp)
        begin
            e = min_exp;
        end
        return e;
    endfunction

endpackage

[rtl/core/scbp_ctrl.sv]
`timescale 1ns / 1ps
// Sequencer of the size-class buffer pool: accept, scan, evaluate, finish.
// Depends on scbp_pkg; drives scbp_dpath through ctl_t.
module scbp_ctrl
    import scbp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    input  sts_t sts,
    output logic s_tready,
    output ctl_t ctl
);

    typedef enum logic [1:0] {S_IDLE, S_READ, S_EVAL, S_FINISH} state_t;

    state_t state_reg;

    // decode commands from the state
    always_comb
    begin
        s_tready  = (state_reg == S_IDLE);
        ctl.latch = (state_reg == S_IDLE) && s_tvalid;
        ctl.rd    = (state_reg == S_READ) && !sts.scan_done;
        ctl.ev    = (state_reg == S_EVAL);
        ctl.fin   = (state_reg == S_FINISH) && sts.out_free;
    end

    // advance the sequence
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        if (sts.acc_cmd == CMD_ALLOC || sts.acc_cmd == CMD_RELEASE)
                        begin
                            state_reg <= S_READ;
                        end
                        else if (sts.acc_cmd == CMD_TRIM)
                        begin
                            state_reg <= sts.over_budget ? S_READ : S_FINISH;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= sts.scan_done ? S_FINISH : S_EVAL;
                end
                S_EVAL:
                begin
                    if (!sts.ev_stall)
                    begin
                        state_reg <= S_READ;
                    end
                end
                S_FINISH:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[rtl/core/scbp_dpath.sv]
`timescale 1ns / 1ps
// Datapath of the size-class buffer pool: entry memory, scan registers,
// running total, configuration and output word. Depends on scbp_pkg.
module scbp_dpath
    import scbp_pkg::*;
#(
    parameter int POOL_ENTRIES  = POOL_ENTRIES_DEF,
    parameter int MIN_CLASS_EXP = MIN_CLASS_EXP_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  ctl_t                  ctl,
    output sts_t                  sts,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [TOTAL_W-1:0]    cfg_wdata
);

    localparam int IDX_W = $clog2(POOL_ENTRIES);
    localparam int CNT_W = $clog2(POOL_ENTRIES + 1);

    entry_t mem [POOL_ENTRIES];

    logic [TOTAL_W-1:0] budget_reg;
    logic [7:0]         delay_reg;
    logic [1:0]         cmd_reg;
    logic [5:0]         cls_reg;
    logic [15:0]        rid_reg;
    logic [31:0]        serial_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic [CNT_W-1:0]   wr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [15:0]        next_ident_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic               sel_vld_reg;
    logic [IDX_W-1:0]   sel_idx_reg;
    entry_t             sel_ent_reg;
    logic               held_vld_reg;
    res_t               held_reg;
    logic [RES_CNT_W-1:0] rem_reg;
    entry_t             rd_ent_reg;
    logic               out_vld_reg;
    res_t               out_reg;
    logic               last_reg;

    logic [TOTAL_W-1:0] ent_size;
    logic [TOTAL_W-1:0] new_size;
    logic               remove;
    logic               ev_go;
    logic               mem_we;
    logic [IDX_W-1:0]   mem_wa;
    entry_t             mem_wd;
    entry_t             new_ent;
    logic               pool_full;

    assign ent_size  = TOTAL_W'(1) << rd_ent_reg.cls;
    assign new_size  = TOTAL_W'(1) << cls_reg;
    assign pool_full = (count_reg == CNT_W'(POOL_ENTRIES));
    assign remove    = (cmd_reg == CMD_TRIM) && !rd_ent_reg.busy
                       && (serial_reg > rd_ent_reg.free_after)
                       && (total_reg > budget_reg)
                       && (rem_reg < RES_CNT_W'(MAX_RESULTS));
    assign ev_go     = ctl.ev && !(remove && held_vld_reg && out_vld_reg);

    always_comb
    begin
        new_ent.ident      = next_ident_reg;
        new_ent.free_after = 32'd0;
        new_ent.busy       = 1'b1;
        new_ent.cls        = cls_reg;
    end

    // status towards the controller
    always_comb
    begin
        sts.acc_cmd     = s_tdata[1:0];
        sts.over_budget = (total_reg > budget_reg);
        sts.scan_done   = (idx_reg == count_reg);
        sts.ev_stall    = ctl.ev && remove && held_vld_reg && out_vld_reg;
        sts.out_free    = !out_vld_reg;
        sts.held_vld    = held_vld_reg;
        sts.count_zero  = (count_reg == '0);
        sts.total_zero  = (total_reg == '0);
    end

    // select the single memory write: trim copy-down or finish update
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = wr_reg[IDX_W-1:0];
        mem_wd = rd_ent_reg;
        if (ev_go && cmd_reg == CMD_TRIM && !remove)
        begin
            mem_we = 1'b1;
        end
        else if (ctl.fin && cmd_reg == CMD_ALLOC)
        begin
            if (sel_vld_reg)
            begin
                mem_we      = 1'b1;
                mem_wa      = sel_idx_reg;
                mem_wd      = sel_ent_reg;
                mem_wd.busy = 1'b1;
            end
            else if (!pool_full)
            begin
                mem_we = 1'b1;
                mem_wa = count_reg[IDX_W-1:0];
                mem_wd = new_ent;
            end
        end
        else if (ctl.fin && cmd_reg == CMD_RELEASE && sel_vld_reg)
        begin
            mem_we             = 1'b1;
            mem_wa             = sel_idx_reg;
            mem_wd             = sel_ent_reg;
            mem_wd.busy        = 1'b0;
            mem_wd.free_after  = serial_reg + 32'(delay_reg);
        end
    end

    // entry memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_wa] <= mem_wd;
        end
        if (ctl.rd)
        begin
            rd_ent_reg <= mem[idx_reg[IDX_W-1:0]];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            budget_reg <= BUDGET_RESET;
            delay_reg  <= DELAY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_BUDGET: budget_reg <= cfg_wdata;
                CFG_DELAY:  delay_reg  <= cfg_wdata[7:0];
                default:    budget_reg <= budget_reg;
            endcase
        end
    end

    // hold the accepted word's fields
    always_ff @(posedge clk)
    begin
        if (ctl.latch)
        begin
            cmd_reg    <= s_tdata[1:0];
            cls_reg    <= class_of(s_tdata[33:2], 6'(MIN_CLASS_EXP));
            rid_reg    <= s_tdata[49:34];
            serial_reg <= s_tdata[81:50];
        end
    end

    // scan, pool state and output word
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg        <= '0;
            wr_reg         <= '0;
            count_reg      <= '0;
            next_ident_reg <= '0;
            total_reg      <= '0;
            sel_vld_reg    <= 1'b0;
            sel_idx_reg    <= '0;
            sel_ent_reg    <= '0;
            held_vld_reg   <= 1'b0;
            held_reg       <= '0;
            rem_reg        <= '0;
            out_vld_reg    <= 1'b0;
            out_reg        <= '0;
            last_reg       <= 1'b0;
        end
        else
        begin
            // drop the output word once taken
            if (out_vld_reg && m_tready)
            begin
                out_vld_reg <= 1'b0;
            end

            if (ctl.latch)
            begin
                idx_reg      <= '0;
                wr_reg       <= '0;
                sel_vld_reg  <= 1'b0;
                held_vld_reg <= 1'b0;
                rem_reg      <= '0;
            end

            // evaluate the entry read in the S_READ state
            if (ev_go)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
                priority case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (!rd_ent_reg.busy && rd_ent_reg.cls >= cls_reg
                            && (!sel_vld_reg || rd_ent_reg.cls < sel_ent_reg.cls))
                        begin
                            sel_vld_reg <= 1'b1;
                            sel_idx_reg <= idx_reg[IDX_W-1:0];
                            sel_ent_reg <= rd_ent_reg;
                        end
                    end
                    CMD_RELEASE:
                    begin
                        if (!sel_vld_reg && rd_ent_reg.ident == rid_reg)
                        begin
                            sel_vld_reg <= 1'b1;
                            sel_idx_reg <= idx_reg[IDX_W-1:0];
                            sel_ent_reg <= rd_ent_reg;
                        end
                    end
                    default:
                    begin
                        if (remove)
                        begin
                            // pass the previous removal on, hold this one
                            if (held_vld_reg)
                            begin
                                out_reg     <= held_reg;
                                last_reg    <= 1'b0;
                                out_vld_reg <= 1'b1;
                            end
                            held_vld_reg    <= 1'b1;
                            held_reg.status <= ST_REMOVED;
                            held_reg.id     <= rd_ent_reg.ident;
                            held_reg.cls    <= rd_ent_reg.cls;
                            held_reg.total  <= total_reg - ent_size;
                            total_reg       <= total_reg - ent_size;
                            rem_reg         <= rem_reg + RES_CNT_W'(1);
                        end
                        else
                        begin
                            wr_reg <= wr_reg + CNT_W'(1);
                        end
                    end
                endcase
            end

            // final result of the command
            if (ctl.fin)
            begin
                out_vld_reg <= 1'b1;
                last_reg    <= 1'b1;
                priority case (cmd_reg)
                    CMD_ALLOC:
                    begin
                        if (sel_vld_reg)
                        begin
                            out_reg <= '{total: total_reg, cls: sel_ent_reg.cls,
                                         id: sel_ent_reg.ident, status: ST_REUSED};
                        end
                        else if (!pool_full)
                        begin
                            out_reg <= '{total: total_reg + new_size, cls: cls_reg,
                                         id: next_ident_reg, status: ST_CREATED};
                            total_reg      <= total_reg + new_size;
                            count_reg      <= count_reg + CNT_W'(1);
                            next_ident_reg <= next_ident_reg + 16'd1;
                        end
                        else
                        begin
                            out_reg <= '{total: total_reg, cls: cls_reg,
                                         id: 16'd0, status: ST_FULL};
                        end
                    end
                    CMD_RELEASE:
                    begin
                        if (sel_vld_reg)
                        begin
                            out_reg <= '{total: total_reg, cls: sel_ent_reg.cls,
                                         id: rid_reg, status: ST_RELEASED};
                        end
                        else
                        begin
                            out_reg <= '{total: total_reg, cls: 6'd0,
                                         id: rid_reg, status: ST_NOT_FOUND};
                        end
                    end
                    default:
                    begin
                        if (held_vld_reg)
                        begin
                            out_reg   <= held_reg;
                            count_reg <= wr_reg;
                        end
                        else
                        begin
                            out_reg <= '{total: total_reg, cls: 6'd0,
                                         id: 16'd0, status: ST_NOTHING};
                        end
                        held_vld_reg <= 1'b0;
                    end
                endcase
            end
        end
    end

    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, out_reg};
    assign m_tlast  = last_reg;

endmodule

[rtl/core/size_class_buffer_pool.sv]
`timescale 1ns / 1ps
// Size-class buffer pool: allocate, release and trim over an ordered pool.
// Usage:
//   Commands enter on the s_ channel, one word per command:
//   tdata = cmd, request_bytes, release_id, current_serial (lowest bits up).
//   Results leave on the m_ channel, one or more words per command,
//   tdata = status, buffer_id, class_exponent, total_bytes; tlast marks the
//   final word of a command. Unknown commands give no word.
//   Allocate, release and trim over budget walk the N entries of one
//   single-port entry memory, one read and one evaluation per entry.
//   Trim under budget skips the walk and gives its result word directly.
//   One command is worked on at a time; s_tready is high only between them.
//   A stalled receiver holds the current output word; trim then pauses at
//   the next removal until the word is taken.
//   cfg_we writes cfg_wdata to register cfg_addr (0 retain budget, 1 delete
//   delay); the user writes only while idle, the block does not enforce it.
//   Reset empties the pool, clears the id counter and loads the register
//   defaults; no clearing pass is needed.
// Depends on scbp_pkg, scbp_ctrl and scbp_dpath.
module size_class_buffer_pool
    import scbp_pkg::*;
#(
    parameter int POOL_ENTRIES  = POOL_ENTRIES_DEF,
    parameter int MIN_CLASS_EXP = MIN_CLASS_EXP_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // cmd[1:0], request_bytes[33:2], release_id[49:34], current_serial[81:50]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // status[2:0], buffer_id[18:3], class_exponent[24:19], total_bytes[62:25]
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_we,
    input  logic                  cfg_addr,
    input  logic [TOTAL_W-1:0]    cfg_wdata
);

    ctl_t ctl;
    sts_t sts;

    scbp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .sts      (sts),
        .s_tready (s_tready),
        .ctl      (ctl)
    );

    scbp_dpath #(
        .POOL_ENTRIES  (POOL_ENTRIES),
        .MIN_CLASS_EXP (MIN_CLASS_EXP)
    ) u_dpath (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .sts       (sts),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

`ifndef SYNTH
    // no removal may be held over once a new command can be taken
    a_held_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !sts.held_vld)
        else $error("removal word held while idle");

    // an empty pool carries no bytes
    a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
        sts.count_zero |-> sts.total_zero)
        else $error("empty pool with non-zero total");

    // trim only pauses while an output word is waiting
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        sts.ev_stall |-> m_tvalid)
        else $error("trim paused with free output");
`endif

endmodule
